>>> hw/rtl/ggpc_pkg.sv
// ----------------------------------------------------------------------------
// ggpc_pkg
// Shared types, constants and tables of the go-to-goal position controller.
// ----------------------------------------------------------------------------
package ggpc_pkg;

  localparam int CORDIC_STAGES = 16;
  localparam int STAGES = (CORDIC_STAGES > 32) ? 32 : CORDIC_STAGES;
  localparam int GUARD = 24;

  localparam logic [31:0] HALF_TURN    = 32'h8000_0000;
  localparam logic [31:0] QUARTER_TURN = 32'h4000_0000;
  // radians to turns in Q18: 2^32 / (2*pi) * 2^2
  localparam logic [31:0] RAD_TO_TURN  = 32'd2734261102;

  typedef enum logic [2:0] {
    REG_TARGET_X      = 3'd0,
    REG_TARGET_Y      = 3'd1,
    REG_SPEED_GAIN    = 3'd2,
    REG_TURN_GAIN     = 3'd3,
    REG_ARRIVE_RADIUS = 3'd4
  } reg_idx_e;

  typedef struct packed {
    logic valid;
    logic arrived;
  } ctl_t;

  localparam logic [31:0] ATAN_TURNS [32] = '{
    32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756, 32'd42667331,
    32'd21354465, 32'd10679838, 32'd5340245, 32'd2670163, 32'd1335087,
    32'd667544, 32'd333772, 32'd166886, 32'd83443, 32'd41722, 32'd20861,
    32'd10430, 32'd5215, 32'd2608, 32'd1304, 32'd652, 32'd326, 32'd163,
    32'd81, 32'd41, 32'd20, 32'd10, 32'd5, 32'd3, 32'd1, 32'd1, 32'd0
  };

  // inverse squared cordic gain in Q62, one factor per active stage
  localparam logic [63:0] IGQ_0  = 64'd1 << 62;
  localparam logic [63:0] IGQ_1  = (STAGES > 0)  ? IGQ_0  - IGQ_0  / 64'd2 : IGQ_0;
  localparam logic [63:0] IGQ_2  = (STAGES > 1)  ? IGQ_1  - IGQ_1  / ((64'd1 << 2) + 64'd1) : IGQ_1;
  localparam logic [63:0] IGQ_3  = (STAGES > 2)  ? IGQ_2  - IGQ_2  / ((64'd1 << 4) + 64'd1) : IGQ_2;
  localparam logic [63:0] IGQ_4  = (STAGES > 3)  ? IGQ_3  - IGQ_3  / ((64'd1 << 6) + 64'd1) : IGQ_3;
  localparam logic [63:0] IGQ_5  = (STAGES > 4)  ? IGQ_4  - IGQ_4  / ((64'd1 << 8) + 64'd1) : IGQ_4;
  localparam logic [63:0] IGQ_6  = (STAGES > 5)  ? IGQ_5  - IGQ_5  / ((64'd1 << 10) + 64'd1) : IGQ_5;
  localparam logic [63:0] IGQ_7  = (STAGES > 6)  ? IGQ_6  - IGQ_6  / ((64'd1 << 12) + 64'd1) : IGQ_6;
  localparam logic [63:0] IGQ_8  = (STAGES > 7)  ? IGQ_7  - IGQ_7  / ((64'd1 << 14) + 64'd1) : IGQ_7;
  localparam logic [63:0] IGQ_9  = (STAGES > 8)  ? IGQ_8  - IGQ_8  / ((64'd1 << 16) + 64'd1) : IGQ_8;
  localparam logic [63:0] IGQ_10 = (STAGES > 9)  ? IGQ_9  - IGQ_9  / ((64'd1 << 18) + 64'd1) : IGQ_9;
  localparam logic [63:0] IGQ_11 = (STAGES > 10) ? IGQ_10 - IGQ_10 / ((64'd1 << 20) + 64'd1) : IGQ_10;
  localparam logic [63:0] IGQ_12 = (STAGES > 11) ? IGQ_11 - IGQ_11 / ((64'd1 << 22) + 64'd1) : IGQ_11;
  localparam logic [63:0] IGQ_13 = (STAGES > 12) ? IGQ_12 - IGQ_12 / ((64'd1 << 24) + 64'd1) : IGQ_12;
  localparam logic [63:0] IGQ_14 = (STAGES > 13) ? IGQ_13 - IGQ_13 / ((64'd1 << 26) + 64'd1) : IGQ_13;
  localparam logic [63:0] IGQ_15 = (STAGES > 14) ? IGQ_14 - IGQ_14 / ((64'd1 << 28) + 64'd1) : IGQ_14;
  localparam logic [63:0] IGQ_16 = (STAGES > 15) ? IGQ_15 - IGQ_15 / ((64'd1 << 30) + 64'd1) : IGQ_15;
  localparam logic [63:0] IGQ_17 = (STAGES > 16) ? IGQ_16 - IGQ_16 / ((64'd1 << 32) + 64'd1) : IGQ_16;
  localparam logic [63:0] IGQ_18 = (STAGES > 17) ? IGQ_17 - IGQ_17 / ((64'd1 << 34) + 64'd1) : IGQ_17;
  localparam logic [63:0] IGQ_19 = (STAGES > 18) ? IGQ_18 - IGQ_18 / ((64'd1 << 36) + 64'd1) : IGQ_18;
  localparam logic [63:0] IGQ_20 = (STAGES > 19) ? IGQ_19 - IGQ_19 / ((64'd1 << 38) + 64'd1) : IGQ_19;
  localparam logic [63:0] IGQ_21 = (STAGES > 20) ? IGQ_20 - IGQ_20 / ((64'd1 << 40) + 64'd1) : IGQ_20;
  localparam logic [63:0] IGQ_22 = (STAGES > 21) ? IGQ_21 - IGQ_21 / ((64'd1 << 42) + 64'd1) : IGQ_21;
  localparam logic [63:0] IGQ_23 = (STAGES > 22) ? IGQ_22 - IGQ_22 / ((64'd1 << 44) + 64'd1) : IGQ_22;
  localparam logic [63:0] IGQ_24 = (STAGES > 23) ? IGQ_23 - IGQ_23 / ((64'd1 << 46) + 64'd1) : IGQ_23;
  localparam logic [63:0] IGQ_25 = (STAGES > 24) ? IGQ_24 - IGQ_24 / ((64'd1 << 48) + 64'd1) : IGQ_24;
  localparam logic [63:0] IGQ_26 = (STAGES > 25) ? IGQ_25 - IGQ_25 / ((64'd1 << 50) + 64'd1) : IGQ_25;
  localparam logic [63:0] IGQ_27 = (STAGES > 26) ? IGQ_26 - IGQ_26 / ((64'd1 << 52) + 64'd1) : IGQ_26;
  localparam logic [63:0] IGQ_28 = (STAGES > 27) ? IGQ_27 - IGQ_27 / ((64'd1 << 54) + 64'd1) : IGQ_27;
  localparam logic [63:0] IGQ_29 = (STAGES > 28) ? IGQ_28 - IGQ_28 / ((64'd1 << 56) + 64'd1) : IGQ_28;
  localparam logic [63:0] IGQ_30 = (STAGES > 29) ? IGQ_29 - IGQ_29 / ((64'd1 << 58) + 64'd1) : IGQ_29;
  localparam logic [63:0] IGQ_31 = (STAGES > 30) ? IGQ_30 - IGQ_30 / ((64'd1 << 60) + 64'd1) : IGQ_30;
  localparam logic [63:0] IGQ_32 = (STAGES > 31) ? IGQ_31 - IGQ_31 / ((64'd1 << 62) + 64'd1) : IGQ_31;

  // Q62 product rounded to Q28
  localparam logic [63:0] INV_GAIN_SQ_FULL = (IGQ_32 + (64'd1 << 33)) >> 34;
  localparam logic [28:0] INV_GAIN_SQ = INV_GAIN_SQ_FULL[28:0];

endpackage

>>> hw/rtl/ggpc_if.sv
// ----------------------------------------------------------------------------
// ggpc_if
// Stream and configuration channels of the go-to-goal position controller.
// ----------------------------------------------------------------------------
interface ggpc_in_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] robot_x;
  logic signed [31:0] robot_y;
  logic signed [31:0] robot_heading;

  modport source (output valid, robot_x, robot_y, robot_heading, input ready);
  modport sink   (input valid, robot_x, robot_y, robot_heading, output ready);
endinterface

interface ggpc_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] forward_speed;
  logic signed [31:0] turn_rate;
  logic               at_target;

  modport source (output valid, forward_speed, turn_rate, at_target, input ready);
  modport sink   (input valid, forward_speed, turn_rate, at_target, output ready);
endinterface

interface ggpc_cfg_if;
  logic        valid;
  logic        ready;
  logic [2:0]  index;
  logic [31:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

>>> hw/rtl/ggpc_front.sv
// ----------------------------------------------------------------------------
// ggpc_front
// Offset to target, heading conversion, arrival test and cordic seed.
// ----------------------------------------------------------------------------
module ggpc_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                en_i,
  input  logic                valid_i,
  input  logic signed [31:0]  robot_x_i,
  input  logic signed [31:0]  robot_y_i,
  input  logic signed [31:0]  robot_heading_i,
  input  logic signed [31:0]  target_x_i,
  input  logic signed [31:0]  target_y_i,
  input  logic [30:0]         arrive_radius_i,
  output ggpc_pkg::ctl_t      ctl_o,
  output logic signed [63:0]  x_o,
  output logic signed [63:0]  y_o,
  output logic [31:0]         bear_o,
  output logic [31:0]         head_o
);

  // stage 1
  logic               v1_q;
  logic signed [32:0] dx_q, dy_q;
  logic signed [63:0] hp_q;
  // stage 2
  logic               v2_q;
  logic               close_q;
  logic [63:0]        sqx_q, sqy_q;
  logic [61:0]        r2_q;
  logic signed [63:0] x2_q, y2_q;
  logic [31:0]        b2_q, h2_q;
  // stage 3
  logic               v3_q, arr3_q;
  logic signed [63:0] x3_q, y3_q;
  logic [31:0]        b3_q, h3_q;

  logic signed [32:0] dx_d, dy_d;
  logic signed [65:0] hp_full;
  logic [32:0]        ax, ay;
  logic [63:0]        hr;
  logic signed [63:0] dxw, dyw;
  logic [64:0]        sq_sum;

  assign dx_d    = 33'(target_x_i) - 33'(robot_x_i);
  assign dy_d    = 33'(target_y_i) - 33'(robot_y_i);
  assign hp_full = 66'(robot_heading_i) * $signed({34'd0, ggpc_pkg::RAD_TO_TURN});

  assign ax  = dx_q[32] ? 33'(-dx_q) : 33'(dx_q);
  assign ay  = dy_q[32] ? 33'(-dy_q) : 33'(dy_q);
  assign hr  = 64'(hp_q) + (64'd1 << 17);
  assign dxw = 64'(dx_q) <<< ggpc_pkg::GUARD;
  assign dyw = 64'(dy_q) <<< ggpc_pkg::GUARD;
  assign sq_sum = 65'(sqx_q) + 65'(sqy_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else if (en_i) begin
      v1_q <= valid_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      dx_q    <= dx_d;
      dy_q    <= dy_d;
      hp_q    <= hp_full[63:0];
      close_q <= (ax <= 33'(arrive_radius_i)) && (ay <= 33'(arrive_radius_i));
      sqx_q   <= 64'(ax * ax);
      sqy_q   <= 64'(ay * ay);
      r2_q    <= arrive_radius_i * arrive_radius_i;
      // fold the left half plane onto the right one
      x2_q    <= dx_q[32] ? -dxw : dxw;
      y2_q    <= dx_q[32] ? -dyw : dyw;
      b2_q    <= dx_q[32] ? ggpc_pkg::HALF_TURN : 32'd0;
      h2_q    <= hr[49:18];
      arr3_q  <= close_q && (sq_sum <= 65'(r2_q));
      x3_q    <= x2_q;
      y3_q    <= y2_q;
      b3_q    <= b2_q;
      h3_q    <= h2_q;
    end
  end

  assign ctl_o.valid   = v3_q;
  assign ctl_o.arrived = arr3_q;
  assign x_o    = x3_q;
  assign y_o    = y3_q;
  assign bear_o = b3_q;
  assign head_o = h3_q;

endmodule

>>> hw/rtl/ggpc_vec.sv
// ----------------------------------------------------------------------------
// ggpc_vec
// Pipelined cordic in vectoring mode: bearing and scaled length of the offset.
// ----------------------------------------------------------------------------
module ggpc_vec (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                en_i,
  input  ggpc_pkg::ctl_t      ctl_i,
  input  logic signed [63:0]  x_i,
  input  logic signed [63:0]  y_i,
  input  logic [31:0]         bear_i,
  input  logic [31:0]         head_i,
  output ggpc_pkg::ctl_t      ctl_o,
  output logic signed [63:0]  x_o,
  output logic [31:0]         bear_o,
  output logic [31:0]         head_o
);

  localparam int N = ggpc_pkg::STAGES;

  ggpc_pkg::ctl_t     ctl_q  [N];
  logic signed [63:0] x_q    [N];
  logic signed [63:0] y_q    [N];
  logic [31:0]        bear_q [N];
  logic [31:0]        head_q [N];

  for (genvar i = 0; i < N; i++) begin : g_stage
    ggpc_pkg::ctl_t     ctl_s;
    logic signed [63:0] xs, ys;
    logic [31:0]        bs, hs;

    if (i == 0) begin : g_first
      assign ctl_s = ctl_i;
      assign xs    = x_i;
      assign ys    = y_i;
      assign bs    = bear_i;
      assign hs    = head_i;
    end else begin : g_next
      assign ctl_s = ctl_q[i-1];
      assign xs    = x_q[i-1];
      assign ys    = y_q[i-1];
      assign bs    = bear_q[i-1];
      assign hs    = head_q[i-1];
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        ctl_q[i] <= '0;
      end else if (en_i) begin
        ctl_q[i] <= ctl_s;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        head_q[i] <= hs;
        if (!ys[63]) begin
          x_q[i]    <= xs + (ys >>> i);
          y_q[i]    <= ys - (xs >>> i);
          bear_q[i] <= bs + ggpc_pkg::ATAN_TURNS[i];
        end else begin
          x_q[i]    <= xs - (ys >>> i);
          y_q[i]    <= ys + (xs >>> i);
          bear_q[i] <= bs - ggpc_pkg::ATAN_TURNS[i];
        end
      end
    end
  end

  assign ctl_o  = ctl_q[N-1];
  assign x_o    = x_q[N-1];
  assign bear_o = bear_q[N-1];
  assign head_o = head_q[N-1];

endmodule

>>> hw/rtl/ggpc_rot.sv
// ----------------------------------------------------------------------------
// ggpc_rot
// Pipelined cordic in rotation mode: turns the length by heading - bearing.
// ----------------------------------------------------------------------------
module ggpc_rot (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                en_i,
  input  ggpc_pkg::ctl_t      ctl_i,
  input  logic signed [63:0]  x_i,
  input  logic [31:0]         bear_i,
  input  logic [31:0]         head_i,
  output ggpc_pkg::ctl_t      ctl_o,
  output logic signed [63:0]  x_o,
  output logic signed [63:0]  y_o
);

  localparam int N = ggpc_pkg::STAGES;

  ggpc_pkg::ctl_t     ctl_p_q;
  logic signed [63:0] x_p_q;
  logic signed [33:0] z_p_q;

  logic [31:0] phi, phi_adj;
  logic [31:0] phi_q1;
  logic        flip;

  assign phi    = head_i - bear_i;
  assign phi_q1 = phi + ggpc_pkg::QUARTER_TURN;
  // angles beyond a quarter turn start from the mirrored vector
  assign flip    = (phi_q1 >= ggpc_pkg::HALF_TURN);
  assign phi_adj = flip ? (phi - ggpc_pkg::HALF_TURN) : phi;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl_p_q <= '0;
    end else if (en_i) begin
      ctl_p_q <= ctl_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      x_p_q <= flip ? -x_i : x_i;
      z_p_q <= 34'($signed(phi_adj));
    end
  end

  ggpc_pkg::ctl_t     ctl_q [N];
  logic signed [63:0] x_q   [N];
  logic signed [63:0] y_q   [N];
  logic signed [33:0] z_q   [N];

  for (genvar i = 0; i < N; i++) begin : g_stage
    ggpc_pkg::ctl_t     ctl_s;
    logic signed [63:0] xs, ys;
    logic signed [33:0] zs, at;

    if (i == 0) begin : g_first
      assign ctl_s = ctl_p_q;
      assign xs    = x_p_q;
      assign ys    = 64'sd0;
      assign zs    = z_p_q;
    end else begin : g_next
      assign ctl_s = ctl_q[i-1];
      assign xs    = x_q[i-1];
      assign ys    = y_q[i-1];
      assign zs    = z_q[i-1];
    end

    assign at = $signed({2'b00, ggpc_pkg::ATAN_TURNS[i]});

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        ctl_q[i] <= '0;
      end else if (en_i) begin
        ctl_q[i] <= ctl_s;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        if (!zs[33]) begin
          x_q[i] <= xs - (ys >>> i);
          y_q[i] <= ys + (xs >>> i);
          z_q[i] <= zs - at;
        end else begin
          x_q[i] <= xs + (ys >>> i);
          y_q[i] <= ys - (xs >>> i);
          z_q[i] <= zs + at;
        end
      end
    end
  end

  assign ctl_o = ctl_q[N-1];
  assign x_o   = x_q[N-1];
  assign y_o   = y_q[N-1];

endmodule

>>> hw/rtl/ggpc_scale.sv
// ----------------------------------------------------------------------------
// ggpc_scale
// Gain correction, gain products and saturation; last stage is the output
// register.
// ----------------------------------------------------------------------------
module ggpc_scale (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                en_i,
  input  ggpc_pkg::ctl_t      ctl_i,
  input  logic signed [63:0]  x_i,
  input  logic signed [63:0]  y_i,
  input  logic signed [31:0]  speed_gain_i,
  input  logic signed [31:0]  turn_gain_i,
  output ggpc_pkg::ctl_t      ctl_o,
  output logic signed [31:0]  forward_speed_o,
  output logic signed [31:0]  turn_rate_o
);

  localparam logic signed [40:0] P_LIM = 41'sd8589934591;

  ggpc_pkg::ctl_t ctl1_q, ctl2_q, ctl3_q, ctl4_q, ctl5_q;

  // stage 1: round to q16.16
  logic signed [39:0] rx_q, ry_q;
  logic signed [63:0] rx_full, ry_full;
  assign rx_full = (x_i + (64'sd1 <<< (ggpc_pkg::GUARD - 1))) >>> ggpc_pkg::GUARD;
  assign ry_full = (y_i + (64'sd1 <<< (ggpc_pkg::GUARD - 1))) >>> ggpc_pkg::GUARD;

  // stage 2: inverse gain product
  logic signed [68:0] px_q, py_q;
  logic signed [28:0] inv_gain;
  assign inv_gain = $signed(ggpc_pkg::INV_GAIN_SQ);

  // stage 3: round back to q16.16, clamp, sign and magnitude against the gains
  logic signed [68:0] qx, qy;
  logic signed [40:0] cx, cy, pf, pt;
  logic [32:0]        mg_f_d, mg_t_d;
  logic [32:0]        mg_f_q, mg_t_q, mp_f_q, mp_t_q;
  logic               neg_f_q, neg_t_q;

  function automatic logic signed [40:0] clamp_p(input logic signed [68:0] v);
    logic signed [40:0] r;
    if (v > 69'(P_LIM)) begin
      r = P_LIM;
    end else if (v < -69'(P_LIM)) begin
      r = -P_LIM;
    end else begin
      r = v[40:0];
    end
    return r;
  endfunction

  assign qx = (px_q + (69'sd1 <<< 27)) >>> 28;
  assign qy = (py_q + (69'sd1 <<< 27)) >>> 28;
  assign cx = clamp_p(qx);
  assign cy = clamp_p(qy);
  assign pf = -cx;
  assign pt = cy;
  assign mg_f_d = speed_gain_i[31] ? 33'(-33'(speed_gain_i)) : 33'(speed_gain_i);
  assign mg_t_d = turn_gain_i[31]  ? 33'(-33'(turn_gain_i))  : 33'(turn_gain_i);

  // stage 4: gain product
  logic [65:0] m_f_q, m_t_q;
  logic        sn_f_q, sn_t_q;

  // stage 5: round on magnitude, saturate
  logic [65:0] mr_f, mr_t;
  logic [31:0] o_f, o_t;
  logic [31:0] fs_q, tr_q;

  function automatic logic [31:0] sat_out(input logic [65:0] m, input logic neg);
    logic [31:0] r;
    if (!neg) begin
      r = (m > 66'h7FFF_FFFF) ? 32'h7FFF_FFFF : m[31:0];
    end else begin
      r = (m >= 66'h8000_0000) ? 32'h8000_0000 : 32'(-m[31:0]);
    end
    return r;
  endfunction

  assign mr_f = (m_f_q + 66'h8000) >> 16;
  assign mr_t = (m_t_q + 66'h8000) >> 16;
  assign o_f  = sat_out(mr_f, sn_f_q);
  assign o_t  = sat_out(mr_t, sn_t_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl1_q <= '0;
      ctl2_q <= '0;
      ctl3_q <= '0;
      ctl4_q <= '0;
      ctl5_q <= '0;
    end else if (en_i) begin
      ctl1_q <= ctl_i;
      ctl2_q <= ctl1_q;
      ctl3_q <= ctl2_q;
      ctl4_q <= ctl3_q;
      ctl5_q <= ctl4_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rx_q    <= rx_full[39:0];
      ry_q    <= ry_full[39:0];
      px_q    <= 69'(rx_q) * 69'(inv_gain);
      py_q    <= 69'(ry_q) * 69'(inv_gain);
      mg_f_q  <= mg_f_d;
      mg_t_q  <= mg_t_d;
      mp_f_q  <= pf[40] ? 33'(-pf) : 33'(pf);
      mp_t_q  <= pt[40] ? 33'(-pt) : 33'(pt);
      neg_f_q <= speed_gain_i[31] ^ pf[40];
      neg_t_q <= turn_gain_i[31] ^ pt[40];
      m_f_q   <= 66'(mg_f_q) * 66'(mp_f_q);
      m_t_q   <= 66'(mg_t_q) * 66'(mp_t_q);
      sn_f_q  <= neg_f_q;
      sn_t_q  <= neg_t_q;
      // arrival forces both commands to zero
      fs_q    <= ctl4_q.arrived ? 32'd0 : o_f;
      tr_q    <= ctl4_q.arrived ? 32'd0 : o_t;
    end
  end

  assign ctl_o           = ctl5_q;
  assign forward_speed_o = $signed(fs_q);
  assign turn_rate_o     = $signed(tr_q);

endmodule

>>> hw/rtl/go_to_goal_position_controller.sv
// ----------------------------------------------------------------------------
// go_to_goal_position_controller
// Go-to-goal unicycle controller: distance and bearing to the target by
// cordic, forward speed and turn rate from the gains.
// ----------------------------------------------------------------------------
//  channel   direction  payload
//  in_i      sink       robot_x, robot_y, robot_heading
//  out_o     source     forward_speed, turn_rate, at_target
//  cfg_i     sink       index, data (always ready)
//
// One item per cycle while the output is not stalled; the pipeline is the front
// stages, the two cordic pipelines and the gain stages.
// Reset clears all valid bits and loads the register reset values.
// Any stall at the output halts the whole pipeline in place, input included.
// ----------------------------------------------------------------------------
module go_to_goal_position_controller (
  input  logic        clk_i,
  input  logic        rst_ni,
  ggpc_in_if.sink     in_i,
  ggpc_out_if.source  out_o,
  ggpc_cfg_if.sink    cfg_i
);

  logic signed [31:0] target_x_q, target_y_q, speed_gain_q, turn_gain_q;
  logic [30:0]        arrive_radius_q;
  logic               en;

  ggpc_pkg::ctl_t     f_ctl, v_ctl, r_ctl, s_ctl;
  logic signed [63:0] f_x, f_y, v_x, r_x, r_y;
  logic [31:0]        f_b, f_h, v_b, v_h;

  assign en          = !s_ctl.valid || out_o.ready;
  assign in_i.ready  = en;
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      target_x_q      <= 32'sd0;
      target_y_q      <= 32'sd0;
      speed_gain_q    <= -32'sd65536;
      turn_gain_q     <= -32'sd1638400;
      arrive_radius_q <= 31'd655;
    end else if (cfg_i.valid) begin
      case (cfg_i.index)
        ggpc_pkg::REG_TARGET_X:      target_x_q      <= $signed(cfg_i.data);
        ggpc_pkg::REG_TARGET_Y:      target_y_q      <= $signed(cfg_i.data);
        ggpc_pkg::REG_SPEED_GAIN:    speed_gain_q    <= $signed(cfg_i.data);
        ggpc_pkg::REG_TURN_GAIN:     turn_gain_q     <= $signed(cfg_i.data);
        ggpc_pkg::REG_ARRIVE_RADIUS: arrive_radius_q <= cfg_i.data[30:0];
        default: ;
      endcase
    end
  end

  ggpc_front u_front (
    .clk_i, .rst_ni, .en_i(en),
    .valid_i(in_i.valid),
    .robot_x_i(in_i.robot_x),
    .robot_y_i(in_i.robot_y),
    .robot_heading_i(in_i.robot_heading),
    .target_x_i(target_x_q),
    .target_y_i(target_y_q),
    .arrive_radius_i(arrive_radius_q),
    .ctl_o(f_ctl), .x_o(f_x), .y_o(f_y), .bear_o(f_b), .head_o(f_h)
  );

  ggpc_vec u_vec (
    .clk_i, .rst_ni, .en_i(en),
    .ctl_i(f_ctl), .x_i(f_x), .y_i(f_y), .bear_i(f_b), .head_i(f_h),
    .ctl_o(v_ctl), .x_o(v_x), .bear_o(v_b), .head_o(v_h)
  );

  ggpc_rot u_rot (
    .clk_i, .rst_ni, .en_i(en),
    .ctl_i(v_ctl), .x_i(v_x), .bear_i(v_b), .head_i(v_h),
    .ctl_o(r_ctl), .x_o(r_x), .y_o(r_y)
  );

  ggpc_scale u_scale (
    .clk_i, .rst_ni, .en_i(en),
    .ctl_i(r_ctl), .x_i(r_x), .y_i(r_y),
    .speed_gain_i(speed_gain_q), .turn_gain_i(turn_gain_q),
    .ctl_o(s_ctl),
    .forward_speed_o(out_o.forward_speed),
    .turn_rate_o(out_o.turn_rate)
  );

  assign out_o.valid     = s_ctl.valid;
  assign out_o.at_target = s_ctl.arrived;

`ifndef SYNTHESIS
  a_arrived_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && out_o.at_target |-> out_o.forward_speed == 32'sd0 &&
                                       out_o.turn_rate == 32'sd0)
    else $error("arrived result with nonzero command");

  a_stall_blocks_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && !out_o.ready |-> !in_i.ready)
    else $error("input taken while output stalled");

  a_stall_holds_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_i.ready |=> $stable(out_o.forward_speed) && $stable(out_o.turn_rate))
    else $error("pipeline moved during stall");
`endif

endmodule

>>> tb/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Drives pose samples and register writes into the go-to-goal controller,
// predicts each command with an independent fixed-point model or takes it from the table, and checks
// each output transfer in order, under random gaps and output stalls.
// ----------------------------------------------------------------------------
module testbench;

  localparam int  LATENCY   = 2 * ggpc_pkg::STAGES + 9;
  localparam int  N_RANDOM  = 730;
  localparam longint LIMIT  = 400000;

  typedef struct {
    logic signed [31:0] fwd;
    logic signed [31:0] turn;
    logic               arrived;
  } cmd_t;

  typedef struct {
    logic signed [31:0] rx;
    logic signed [31:0] ry;
    logic signed [31:0] hd;
    bit                 known;  // expected result typed into the table
    cmd_t               cmd;
  } pose_row_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  ggpc_in_if  pose_ch ();
  ggpc_out_if cmd_ch ();
  ggpc_cfg_if cfg_ch ();

  go_to_goal_position_controller dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (pose_ch.sink),
    .out_o  (cmd_ch.source),
    .cfg_i  (cfg_ch.sink)
  );

  always #6 clk_i = ~clk_i;

  // register copies used by the predictor
  logic signed [31:0] tgt_x, tgt_y, spd_gain, trn_gain;
  logic        [30:0] radius;

  cmd_t   cmd_queue[$];
  int     n_errors;
  longint cycle_count;
  bit     stall_hold;  // output held ready while set, no new stalls
  int     stall_level;

  logic [31:0] atan_lut [32];

  initial begin
    atan_lut = '{
      32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756, 32'd42667331,
      32'd21354465, 32'd10679838, 32'd5340245, 32'd2670163, 32'd1335087,
      32'd667544, 32'd333772, 32'd166886, 32'd83443, 32'd41722, 32'd20861,
      32'd10430, 32'd5215, 32'd2608, 32'd1304, 32'd652, 32'd326, 32'd163,
      32'd81, 32'd41, 32'd20, 32'd10, 32'd5, 32'd3, 32'd1, 32'd1, 32'd0
    };
  end

  function automatic longint rnd_shift(longint v, int s);
    return (v + (longint'(1) << (s - 1))) >>> s;
  endfunction

  function automatic longint inv_gain_q28();
    logic [63:0] q;
    q = 64'd1 << 62;
    for (int i = 0; i < ggpc_pkg::STAGES; i++) q = q - q / ((64'd1 << (2 * i)) + 64'd1);
    return longint'((q + (64'd1 << 33)) >> 34);
  endfunction

  function automatic longint unscale(longint v, longint k);
    longint p, lim;
    p = rnd_shift(rnd_shift(v, ggpc_pkg::GUARD) * k, 28);
    lim = (longint'(1) << 33) - 1;
    if (p > lim) p = lim;
    if (p < -lim) p = -lim;
    return p;
  endfunction

  function automatic logic [31:0] gain_mul(logic signed [31:0] g, longint p);
    bit          neg;
    logic [63:0] mg, mp, m;
    neg = (g < 0) != (p < 0);
    mg = (g < 0) ? -longint'(g) : longint'(g);
    mp = (p < 0) ? -p : p;
    m = (mg * mp + 64'h8000) >> 16;
    if (!neg) return (m > 64'h7FFF_FFFF) ? 32'h7FFF_FFFF : m[31:0];
    if (m > 64'h8000_0000) m = 64'h8000_0000;
    return 32'd0 - m[31:0];
  endfunction

  function automatic cmd_t steer_cmd(logic signed [31:0] rx, logic signed [31:0] ry,
                                     logic signed [31:0] hd);
    cmd_t        c;
    longint      dx, dy, x, y, t, zs, k;
    logic [63:0] ax, ay, r;
    logic [31:0] bearing, h, phi;
    dx = longint'(tgt_x) - longint'(rx);
    dy = longint'(tgt_y) - longint'(ry);
    ax = (dx < 0) ? -dx : dx;
    ay = (dy < 0) ? -dy : dy;
    r = 64'(radius);
    if (ax <= r && ay <= r && ax * ax + ay * ay <= r * r) begin
      c.fwd = 0;
      c.turn = 0;
      c.arrived = 1'b1;
      return c;
    end
    bearing = 0;
    x = dx <<< ggpc_pkg::GUARD;
    y = dy <<< ggpc_pkg::GUARD;
    if (x < 0) begin
      bearing = ggpc_pkg::HALF_TURN;
      x = -x;
      y = -y;
    end
    for (int i = 0; i < ggpc_pkg::STAGES; i++) begin
      t = x;
      if (y >= 0) begin
        x = x + (y >>> i);
        y = y - (t >>> i);
        bearing = bearing + atan_lut[i];
      end else begin
        x = x - (y >>> i);
        y = y + (t >>> i);
        bearing = bearing - atan_lut[i];
      end
    end
    h = 32'(rnd_shift(longint'(hd) * longint'(64'd2734261102), 18));
    phi = h - bearing;
    y = 0;
    if (phi + ggpc_pkg::QUARTER_TURN >= ggpc_pkg::HALF_TURN) begin
      x = -x;
      phi = phi - ggpc_pkg::HALF_TURN;
    end
    zs = longint'(signed'(phi));
    for (int i = 0; i < ggpc_pkg::STAGES; i++) begin
      t = x;
      if (zs >= 0) begin
        x = x - (y >>> i);
        y = y + (t >>> i);
        zs = zs - longint'(atan_lut[i]);
      end else begin
        x = x + (y >>> i);
        y = y - (t >>> i);
        zs = zs + longint'(atan_lut[i]);
      end
    end
    k = inv_gain_q28();
    c.fwd = gain_mul(spd_gain, -unscale(x, k));
    c.turn = gain_mul(trn_gain, unscale(y, k));
    c.arrived = 1'b0;
    return c;
  endfunction

  task automatic idle_gap();
    int n;
    n = ($urandom_range(0, 19) == 0) ? $urandom_range(10, 60)
                                     : $urandom_range(0, 2);
    if ($urandom_range(0, 3) == 0) n = 0;
    repeat (n) @(posedge clk_i);
  endtask

  task automatic write_reg(ggpc_pkg::reg_idx_e idx, logic [31:0] val);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= val;
    do @(posedge clk_i); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
    case (idx)
      ggpc_pkg::REG_TARGET_X:      tgt_x = val;
      ggpc_pkg::REG_TARGET_Y:      tgt_y = val;
      ggpc_pkg::REG_SPEED_GAIN:    spd_gain = val;
      ggpc_pkg::REG_TURN_GAIN:     trn_gain = val;
      ggpc_pkg::REG_ARRIVE_RADIUS: radius = val[30:0];
      default: ;
    endcase
    @(posedge clk_i);
  endtask

  task automatic drain();
    while (cmd_queue.size() != 0) @(posedge clk_i);
    repeat (LATENCY + 4) @(posedge clk_i);
  endtask

  task automatic send_pose(pose_row_t row);
    pose_ch.valid         <= 1'b1;
    pose_ch.robot_x       <= row.rx;
    pose_ch.robot_y       <= row.ry;
    pose_ch.robot_heading <= row.hd;
    do @(posedge clk_i); while (!pose_ch.ready);
    cmd_queue.push_back(row.known ? row.cmd : steer_cmd(row.rx, row.ry, row.hd));
    if ($urandom_range(0, 2) == 0) begin
      pose_ch.valid <= 1'b0;
      @(posedge clk_i);
      idle_gap();
    end
  endtask

  task automatic send_end();
    pose_ch.valid <= 1'b0;
  endtask

  function automatic logic signed [31:0] rand_coord();
    case ($urandom_range(0, 3))
      0:       return $urandom;
      1:       return $urandom_range(0, 1 << 22) - (1 << 21);
      2:       return $urandom_range(0, 2000) - 1000;
      default: return $urandom_range(0, 1 << 26) - (1 << 25);
    endcase
  endfunction

  // output side: check on every transfer
  always @(posedge clk_i) begin
    cmd_t want;
    if (rst_ni && cmd_ch.valid && cmd_ch.ready) begin
      if (cmd_queue.size() == 0) begin
        n_errors++;
        if (n_errors <= 10) $display("unexpected output transfer %0d %0d %0b",
                                     cmd_ch.forward_speed, cmd_ch.turn_rate,
                                     cmd_ch.at_target);
      end else begin
        want = cmd_queue.pop_front();
        if (cmd_ch.forward_speed !== want.fwd || cmd_ch.turn_rate !== want.turn ||
            cmd_ch.at_target !== want.arrived) begin
          n_errors++;
          if (n_errors <= 10)
            $display("mismatch: expected %0d %0d %0b, got %0d %0d %0b",
                     want.fwd, want.turn, want.arrived, cmd_ch.forward_speed,
                     cmd_ch.turn_rate, cmd_ch.at_target);
        end
      end
    end
  end

  // output stalls
  always @(posedge clk_i) begin
    if (stall_level > 0) begin
      stall_level <= stall_level - 1;
      cmd_ch.ready <= 1'b0;
    end else if (stall_hold) begin
      cmd_ch.ready <= 1'b1;
    end else if ($urandom_range(0, 39) == 0) begin
      stall_level <= $urandom_range(10, 50);
      cmd_ch.ready <= 1'b0;
    end else begin
      cmd_ch.ready <= ($urandom_range(0, 3) != 0);
    end
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > LIMIT) begin
      $display("testbench failed");
      $finish;
    end
  end

  pose_row_t directed[$];

  function automatic pose_row_t row_of(logic signed [31:0] rx, logic signed [31:0] ry,
                                       logic signed [31:0] hd, bit known = 0,
                                       bit arr = 0);
    pose_row_t r;
    r.rx = rx;
    r.ry = ry;
    r.hd = hd;
    r.known = known;
    r.cmd.fwd = 0;
    r.cmd.turn = 0;
    r.cmd.arrived = arr;
    return r;
  endfunction

  initial begin
    pose_row_t row;
    n_errors = 0;
    cycle_count = 0;
    stall_hold = 0;
    stall_level = 0;
    pose_ch.valid = 1'b0;
    pose_ch.robot_x = 0;
    pose_ch.robot_y = 0;
    pose_ch.robot_heading = 0;
    cfg_ch.valid = 1'b0;
    cfg_ch.index = ggpc_pkg::REG_TARGET_X;
    cfg_ch.data = 0;
    cmd_ch.ready = 1'b1;
    tgt_x = 0;
    tgt_y = 0;
    spd_gain = -32'sd65536;
    trn_gain = -32'sd1638400;
    radius = 31'd655;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset registers: at the origin, on and just past the arrival radius
    directed.push_back(row_of(0, 0, 0, 1, 1));
    directed.push_back(row_of(655, 0, 32'sh7FFF_FFFF, 1, 1));
    directed.push_back(row_of(0, -655, 0, 1, 1));
    directed.push_back(row_of(463, 463, 0, 1, 1));
    directed.push_back(row_of(656, 0, 0));
    directed.push_back(row_of(464, 463, 0));
    directed.push_back(row_of(65536, 65536, 205887));
    directed.push_back(row_of(-65536, 0, -205887));
    directed.push_back(row_of(0, 65536, 102944));
    // field extremes
    directed.push_back(row_of(32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh8000_0000));
    directed.push_back(row_of(32'sh8000_0000, 32'sh8000_0000, 32'sh7FFF_FFFF));
    directed.push_back(row_of(32'sh8000_0000, 32'sh7FFF_FFFF, -1));
    directed.push_back(row_of(-1, 1, 1));
    directed.push_back(row_of(32'sh5555_5555, 32'shAAAA_AAAA, 32'sh5555_5555));
    foreach (directed[i]) send_pose(directed[i]);
    send_end();
    drain();

    // extreme registers: saturation, widest radius, extreme targets
    write_reg(ggpc_pkg::REG_TARGET_X, 32'h7FFF_FFFF);
    write_reg(ggpc_pkg::REG_TARGET_Y, 32'h8000_0000);
    write_reg(ggpc_pkg::REG_SPEED_GAIN, 32'h7FFF_FFFF);
    write_reg(ggpc_pkg::REG_TURN_GAIN, 32'h8000_0000);
    write_reg(ggpc_pkg::REG_ARRIVE_RADIUS, 32'h7FFF_FFFF);
    directed.delete();
    directed.push_back(row_of(0, 0, 0));
    directed.push_back(row_of(32'sh7FFF_FFFF, 32'sh8000_0000, 0, 1, 1));
    directed.push_back(row_of(32'sh8000_0000, 32'sh7FFF_FFFF, 300000));
    directed.push_back(row_of(32'sh7FFF_FFFF, 0, -300000));
    foreach (directed[i]) send_pose(directed[i]);
    send_end();
    // sender holds off until every command is back
    drain();
    write_reg(ggpc_pkg::reg_idx_e'(3'd7), 32'h1234_5678);  // out-of-range index, ignored
    write_reg(ggpc_pkg::REG_ARRIVE_RADIUS, 32'h0);

    for (int phase = 0; phase < 5; phase++) begin
      if (phase > 0) begin
        write_reg(ggpc_pkg::REG_TARGET_X, rand_coord());
        write_reg(ggpc_pkg::REG_TARGET_Y, rand_coord());
        write_reg(ggpc_pkg::REG_SPEED_GAIN,
                  (phase == 4) ? 32'h8000_0000 : $urandom_range(0, 1 << 20) - (1 << 19));
        write_reg(ggpc_pkg::REG_TURN_GAIN, (phase == 3) ? 32'h7FFF_FFFF : $urandom);
        write_reg(ggpc_pkg::REG_ARRIVE_RADIUS,
                  (phase == 2) ? 32'h0 : $urandom_range(0, 1 << 18));
      end
      stall_hold = (phase == 1);
      for (int i = 0; i < N_RANDOM / 5; i++) begin
        row.rx = rand_coord();
        row.ry = rand_coord();
        row.hd = $urandom;
        row.known = 0;
        // near the target now and then so the arrival test gets hits
        if ($urandom_range(0, 5) == 0) begin
          row.rx = tgt_x + 32'((int'($urandom_range(0, 2 * radius)) - int'(radius)) / 2);
          row.ry = tgt_y + 32'((int'($urandom_range(0, 2 * radius)) - int'(radius)) / 2);
        end
        send_pose(row);
      end
      send_end();
      drain();
    end
    stall_hold = 0;

    if (n_errors == 0 && cmd_queue.size() == 0) begin
      $display("testbench passed");
    end else begin
      $display("testbench failed");
    end
    $finish;
  end

endmodule
